FILE: sv/assert_macros.svh
// assertion macros for the button debounce design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define BDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BDC_ASSERT(label, prop, msg)
`define BDC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: sv/bdc_pkg.sv
// types and constants for the button debounce and click detector
`default_nettype none

package bdc_pkg;

  // poll commands
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_PRIME   = 2'd2,
    CMD_TAKE    = 2'd3
  } cmd_e;

  // pending event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_DOUBLE  = 3'd4,
    EV_MULTI   = 3'd5,
    EV_BOOT    = 3'd6
  } ev_e;

  // configuration register indexes (word address)
  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_MULTI_WIN  = 3'd2,
    REG_BOOT_HOLD  = 3'd3,
    REG_ACTIVE_LOW = 3'd4
  } reg_idx_e;

  localparam int unsigned AddrWidth = 5;

  localparam logic [15:0] DebounceReset   = 16'd20;
  localparam logic [31:0] LongPressReset  = 32'd800;
  localparam logic [15:0] MultiWinReset   = 16'd300;
  localparam logic [31:0] BootHoldReset   = 32'd2000;
  localparam logic        ActiveLowReset  = 1'b1;

  localparam logic [7:0]  ClickMax    = 8'd255;
  localparam logic [7:0]  DoubleCount = 8'd2;

endpackage

`default_nettype wire

FILE: sv/button_debounce_click_detector.sv
// button debounce, click counting, long press and boot hold detection
//
//   channel   direction  handshake              payload
//   poll      in         in_valid_i / in_stall_o cmd_i, pin_level_i, now_ms_i
//   result    out        out_valid_o / out_stall_i
//                                   pressed_o, event_res_o, finished_clicks_o,
//                                   held_for_o, previous_hold_o
//   config    in         apb write/read         paddr, pwdata, prdata
//
// a poll passes through the input register, then through the update logic
// into the result register
// one poll per cycle sustained while the output is not stalled; the state
// update is a single pass of parallel 32 bit subtract-and-compare units
// reset clears detector state, valid, event and ready flags, loads register defaults
// an output stall holds the result register; the input register still takes
// a poll while it is empty, then stalls the input side as well
`default_nettype none

`include "assert_macros.svh"

module button_debounce_click_detector
  import bdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // poll channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic                 pin_level_i,
  input  wire logic [31:0]          now_ms_i,

  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      pressed_o,
  output logic [2:0]                event_res_o,
  output logic [7:0]                finished_clicks_o,
  output logic [31:0]               held_for_o,
  output logic [31:0]               previous_hold_o,

  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] debounce_q;
  logic [31:0] long_press_q;
  logic [15:0] multi_win_q;
  logic [31:0] boot_hold_q;
  logic        active_low_q;

  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
      multi_win_q  <= MultiWinReset;
      boot_hold_q  <= BootHoldReset;
      active_low_q <= ActiveLowReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[15:0];
        REG_LONG_PRESS: long_press_q <= pwdata;
        REG_MULTI_WIN:  multi_win_q  <= pwdata[15:0];
        REG_BOOT_HOLD:  boot_hold_q  <= pwdata;
        REG_ACTIVE_LOW: active_low_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, debounce_q};
      REG_LONG_PRESS: prdata = long_press_q;
      REG_MULTI_WIN:  prdata = {16'd0, multi_win_q};
      REG_BOOT_HOLD:  prdata = boot_hold_q;
      REG_ACTIVE_LOW: prdata = {31'd0, active_low_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input register and flow control
  // ---------------------------------------------------------------------
  logic        in_valid_q;
  cmd_e        cmd_q;
  logic        pin_q;
  logic [31:0] now_q;
  logic        out_valid_q;
  logic        advance;   // result register can take a new value
  logic        proc;      // the poll in the input register is processed now

  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= cmd_e'(cmd_i);
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------------
  // detector state
  // ---------------------------------------------------------------------
  logic        raw_seen_q,   raw_seen_d;
  logic        stable_q,     stable_d;
  logic        long_fired_q, long_fired_d;
  logic [31:0] change_q,     change_d;
  logic [31:0] press_q,      press_d;
  logic [31:0] release_q,    release_d;
  logic [31:0] last_dur_q,   last_dur_d;
  logic [7:0]  click_run_q,  click_run_d;
  logic [7:0]  final_q,      final_d;
  ev_e         pending_q,    pending_d;
  logic [31:0] start_q,      start_d;
  logic        boot_armed_q, boot_armed_d;
  logic        boot_fired_q, boot_fired_d;
  logic        ready_q,      ready_d;

  // elapsed times against the stored stamps, all in parallel
  logic [31:0] since_change, since_press, since_release, since_start;
  logic        rawp;
  logic        raw_chg, deb_ok, edge_press, edge_release;
  logic        long_ok, rel_win_ok, boot_ok;

  ev_e         res_event;
  logic [31:0] res_held;

  assign since_change  = now_q - change_q;
  assign since_press   = now_q - press_q;
  assign since_release = now_q - release_q;
  assign since_start   = now_q - start_q;

  assign rawp    = active_low_q ? !pin_q : pin_q;
  assign raw_chg = rawp != raw_seen_q;

  // a fresh stamp equals now, so its elapsed time is zero
  assign deb_ok       = raw_chg ? (debounce_q == 16'd0)
                                : (since_change >= {16'd0, debounce_q});
  assign edge_press   = deb_ok && rawp && !stable_q;
  assign edge_release = deb_ok && !rawp && stable_q;
  assign long_ok      = edge_press ? (long_press_q == 32'd0)
                                   : (since_press >= long_press_q);
  assign rel_win_ok   = edge_release ? (multi_win_q == 16'd0)
                                     : (since_release >= {16'd0, multi_win_q});
  assign boot_ok      = since_start >= boot_hold_q;

  always_comb begin
    raw_seen_d   = raw_seen_q;
    stable_d     = stable_q;
    long_fired_d = long_fired_q;
    change_d     = change_q;
    press_d      = press_q;
    release_d    = release_q;
    last_dur_d   = last_dur_q;
    click_run_d  = click_run_q;
    final_d      = final_q;
    pending_d    = pending_q;
    start_d      = start_q;
    boot_armed_d = boot_armed_q;
    boot_fired_d = boot_fired_q;
    ready_d      = ready_q;

    unique case (cmd_q)
      CMD_RESTART, CMD_PRIME: begin
        raw_seen_d   = 1'b0;
        stable_d     = 1'b0;
        long_fired_d = 1'b0;
        change_d     = 32'd0;
        press_d      = 32'd0;
        release_d    = 32'd0;
        last_dur_d   = 32'd0;
        click_run_d  = 8'd0;
        final_d      = 8'd0;
        pending_d    = EV_NONE;
        start_d      = now_q;
        boot_armed_d = 1'b0;
        boot_fired_d = 1'b0;
        if (cmd_q == CMD_PRIME) begin
          raw_seen_d   = rawp;
          stable_d     = rawp;
          press_d      = now_q;
          change_d     = now_q;
          boot_armed_d = rawp;
          ready_d      = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (ready_q) begin
          if (raw_chg) begin
            raw_seen_d = rawp;
            change_d   = now_q;
          end
          if (edge_press) begin
            stable_d     = 1'b1;
            long_fired_d = 1'b0;
            press_d      = now_q;
            pending_d    = EV_PRESS;
          end
          if (edge_release) begin
            stable_d   = 1'b0;
            release_d  = now_q;
            last_dur_d = since_press;
            if (!long_fired_q) begin
              if (click_run_q == 8'd0 || !(since_release >= {16'd0, multi_win_q})) begin
                if (click_run_q != ClickMax) begin
                  click_run_d = click_run_q + 8'd1;
                end
              end else begin
                click_run_d = 8'd1;
              end
            end else begin
              click_run_d = 8'd0;
            end
            boot_armed_d = 1'b0;
            pending_d    = EV_RELEASE;
          end
          // one-shot long press
          if (stable_d && !long_fired_d && long_ok) begin
            long_fired_d = 1'b1;
            click_run_d  = 8'd0;
            pending_d    = EV_LONG;
          end
          // held since prime
          if (boot_armed_d && !boot_fired_q && stable_d && boot_ok) begin
            boot_fired_d = 1'b1;
            pending_d    = EV_BOOT;
          end
          // click window closed: finalize the run
          if (click_run_d != 8'd0 && !stable_d && rel_win_ok) begin
            final_d = click_run_d;
            if (click_run_d == DoubleCount) begin
              pending_d = EV_DOUBLE;
            end else if (click_run_d > DoubleCount) begin
              pending_d = EV_MULTI;
            end
            click_run_d = 8'd0;
          end
        end
      end
      CMD_TAKE: begin
        if (ready_q) begin
          pending_d = EV_NONE;
        end
      end
      default: ;
    endcase
  end

  // a take reports the event it clears; otherwise the event after the update
  assign res_event = (cmd_q == CMD_TAKE) ? pending_q : pending_d;
  assign res_held  = stable_d ? (now_q - press_d) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_seen_q   <= 1'b0;
      stable_q     <= 1'b0;
      long_fired_q <= 1'b0;
      change_q     <= 32'd0;
      press_q      <= 32'd0;
      release_q    <= 32'd0;
      last_dur_q   <= 32'd0;
      click_run_q  <= 8'd0;
      final_q      <= 8'd0;
      pending_q    <= EV_NONE;
      start_q      <= 32'd0;
      boot_armed_q <= 1'b0;
      boot_fired_q <= 1'b0;
      ready_q      <= 1'b0;
    end else if (proc) begin
      raw_seen_q   <= raw_seen_d;
      stable_q     <= stable_d;
      long_fired_q <= long_fired_d;
      change_q     <= change_d;
      press_q      <= press_d;
      release_q    <= release_d;
      last_dur_q   <= last_dur_d;
      click_run_q  <= click_run_d;
      final_q      <= final_d;
      pending_q    <= pending_d;
      start_q      <= start_d;
      boot_armed_q <= boot_armed_d;
      boot_fired_q <= boot_fired_d;
      ready_q      <= ready_d;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic        res_pressed_q;
  ev_e         res_event_q;
  logic [7:0]  res_clicks_q;
  logic [31:0] res_held_q;
  logic [31:0] res_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // everything reads zero until primed
  always_ff @(posedge clk_i) begin
    if (proc) begin
      if (ready_d) begin
        res_pressed_q <= stable_d;
        res_event_q   <= res_event;
        res_clicks_q  <= final_d;
        res_held_q    <= res_held;
        res_prev_q    <= last_dur_d;
      end else begin
        res_pressed_q <= 1'b0;
        res_event_q   <= EV_NONE;
        res_clicks_q  <= 8'd0;
        res_held_q    <= 32'd0;
        res_prev_q    <= 32'd0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pressed_o         = res_pressed_q;
  assign event_res_o       = res_event_q;
  assign finished_clicks_o = res_clicks_q;
  assign held_for_o        = res_held_q;
  assign previous_hold_o   = res_prev_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `BDC_ASSERT(a_ready_sticky, !$fell(ready_q), "ready dropped after prime")
  `BDC_ASSERT(a_unprimed_zero, (out_valid_q && !ready_q) |-> (!res_pressed_q && res_event_q == EV_NONE && res_held_q == 32'd0 && res_prev_q == 32'd0), "result not zero before prime")
  `BDC_ASSERT(a_held_when_pressed, (out_valid_q && !res_pressed_q) |-> (res_held_q == 32'd0), "held time while released")
  `BDC_ASSERT(a_result_from_poll, $rose(out_valid_q) |-> $past(in_valid_q), "result with no poll behind it")
  `BDC_ASSERT_ALWAYS(a_no_stall_when_empty, !in_valid_q |-> !in_stall_o, "input stalled with empty register")

endmodule

`default_nettype wire

FILE: verif/button_debounce_click_detector_tb.sv
// testbench for the button debounce and click detector: poll stimulus, inline predictor, scoreboard
`timescale 1ns / 100ps

module button_debounce_click_detector_tb;
  import bdc_pkg::*;

  localparam int unsigned ClockPeriod   = 20;
  localparam int unsigned ResetCycles   = 9;
  // poll transfer to result passes the input register and the result register
  localparam int unsigned ResultLatency = 2;
  localparam int unsigned LongHold      = 60;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned ClickBurst    = 257;

  // kinds of register setting that a random phase runs under
  typedef enum int unsigned {
    PH_RESET,
    PH_TIGHT,
    PH_ZERO,
    PH_MAX
  } phase_kind_e;

  // one result transfer, field by field
  typedef struct packed {
    logic        pressed;
    logic [2:0]  ev;
    logic [7:0]  clicks;
    logic [31:0] held;
    logic [31:0] prev_hold;
  } poll_result_t;

  // expected results from a private copy of the detector state
  class click_scoreboard;
    logic [15:0]  deb_time;
    logic [31:0]  long_ms;
    logic [15:0]  window_ms;
    logic [31:0]  boot_ms;
    logic         low_active;
    logic         raw_seen, stable_pressed, long_fired, boot_armed, boot_fired, primed;
    logic [31:0]  change_stamp, press_stamp, release_stamp, last_duration, start_stamp;
    logic [7:0]   click_run, done_clicks;
    ev_e          pending_ev;
    poll_result_t expected_q[$];
    int unsigned  errors;

    function new();
      errors         = 0;
      deb_time       = DebounceReset;
      long_ms        = LongPressReset;
      window_ms      = MultiWinReset;
      boot_ms        = BootHoldReset;
      low_active     = ActiveLowReset;
      clear_state(32'd0);
      primed         = 1'b0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE:   deb_time    = value[15:0];
        REG_LONG_PRESS: long_ms     = value;
        REG_MULTI_WIN:  window_ms   = value[15:0];
        REG_BOOT_HOLD:  boot_ms     = value;
        REG_ACTIVE_LOW: low_active  = value[0];
        default: ;
      endcase
    endfunction

    function void clear_state(logic [31:0] now);
      raw_seen       = 1'b0;
      stable_pressed = 1'b0;
      long_fired     = 1'b0;
      change_stamp   = '0;
      press_stamp    = '0;
      release_stamp  = '0;
      last_duration  = '0;
      click_run      = '0;
      done_clicks    = '0;
      pending_ev     = EV_NONE;
      start_stamp    = now;
      boot_armed     = 1'b0;
      boot_fired     = 1'b0;
    endfunction

    function void debounce_sample(logic p, logic [31:0] now);
      logic [31:0] prev_release;
      logic [31:0] since_change, since_press, since_start, since_release;
      if (p != raw_seen) begin
        raw_seen     = p;
        change_stamp = now;
      end
      since_change = now - change_stamp;
      if (since_change >= {16'd0, deb_time} && p != stable_pressed) begin
        stable_pressed = p;
        if (p) begin
          long_fired  = 1'b0;
          press_stamp = now;
          pending_ev  = EV_PRESS;
        end else begin
          prev_release  = release_stamp;
          release_stamp = now;
          last_duration = now - press_stamp;
          // a press that already gave a long press adds no click
          if (!long_fired) begin
            since_release = now - prev_release;
            if (click_run == 8'd0 || since_release < {16'd0, window_ms}) begin
              if (click_run != ClickMax) click_run++;
            end else begin
              click_run = 8'd1;
            end
          end else begin
            click_run = 8'd0;
          end
          boot_armed = 1'b0;
          pending_ev = EV_RELEASE;
        end
      end
      since_press = now - press_stamp;
      if (stable_pressed && !long_fired && since_press >= long_ms) begin
        long_fired = 1'b1;
        click_run  = 8'd0;
        pending_ev = EV_LONG;
      end
      since_start = now - start_stamp;
      if (boot_armed && !boot_fired && stable_pressed && since_start >= boot_ms) begin
        boot_fired = 1'b1;
        pending_ev = EV_BOOT;
      end
      since_release = now - release_stamp;
      if (click_run != 8'd0 && !stable_pressed && since_release >= {16'd0, window_ms}) begin
        done_clicks = click_run;
        if (click_run == DoubleCount) pending_ev = EV_DOUBLE;
        else if (click_run > DoubleCount) pending_ev = EV_MULTI;
        click_run = 8'd0;
      end
    endfunction

    // called on every poll transfer
    function void note_poll(cmd_e c, logic pin, logic [31:0] now);
      logic         p;
      poll_result_t r;
      p = low_active ? ~pin : pin;
      case (c)
        CMD_RESTART: clear_state(now);
        CMD_PRIME: begin
          clear_state(now);
          raw_seen       = p;
          stable_pressed = p;
          press_stamp    = now;
          change_stamp   = now;
          boot_armed     = p;
          primed         = 1'b1;
        end
        CMD_SAMPLE: if (primed) debounce_sample(p, now);
        default: ;
      endcase
      r = '0;
      if (primed) begin
        r.pressed   = stable_pressed;
        r.ev        = pending_ev;
        r.clicks    = done_clicks;
        r.held      = stable_pressed ? now - press_stamp : 32'd0;
        r.prev_hold = last_duration;
        if (c == CMD_TAKE) pending_ev = EV_NONE;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // called on every result transfer
    function void check_result(poll_result_t got);
      poll_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no poll waiting for it");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
      compare_field("event_res", 32'(want.ev), 32'(got.ev));
      compare_field("finished_clicks", 32'(want.clicks), 32'(got.clicks));
      compare_field("held_for", want.held, got.held);
      compare_field("previous_hold", want.prev_hold, got.prev_hold);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // block ports, the inputs driven to known values from time zero
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           cmd_i = CMD_SAMPLE;
  logic                 pin_level_i = 1'b0;
  logic [31:0]          now_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 pressed_o;
  logic [2:0]           event_res_o;
  logic [7:0]           finished_clicks_o;
  logic [31:0]          held_for_o;
  logic [31:0]          previous_hold_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  click_scoreboard sb = new();

  // stimulus-side view of time and polarity
  logic [31:0] clock_ms = 32'd1000;
  logic        cur_active_low = ActiveLowReset;
  logic [31:0] step_max = 32'd100;
  // idle modes: calm means no gaps on that side
  logic        sender_calm = 1'b0;
  logic        receiver_calm = 1'b0;
  // asks the result side for one long stall
  logic        hold_request = 1'b0;

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  button_debounce_click_detector i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .pin_level_i       (pin_level_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pressed_o         (pressed_o),
    .event_res_o       (event_res_o),
    .finished_clicks_o (finished_clicks_o),
    .held_for_o        (held_for_o),
    .previous_hold_o   (previous_hold_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // pin level that reads as the given debounced state
  function automatic logic pin_for(logic pressed_lvl);
    return cur_active_low ? ~pressed_lvl : pressed_lvl;
  endfunction

  // offer one poll; valid stays high into the next poll when there is no gap
  task automatic put_poll(cmd_e c, logic pin, logic [31:0] stamp);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    pin_level_i <= pin;
    now_ms_i    <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_poll(c, pin, stamp);
  endtask

  task automatic sample_after(logic pressed_lvl, logic [31:0] dt);
    clock_ms += dt;
    put_poll(CMD_SAMPLE, pin_for(pressed_lvl), clock_ms);
  endtask

  // a few samples at one level, time moving on by random steps
  task automatic hold_level(logic pressed_lvl, int unsigned n, logic [31:0] span);
    repeat (n) sample_after(pressed_lvl, $urandom_range(0, span));
  endtask

  // contact bounce: the level flips on consecutive polls
  task automatic bounce(logic first_lvl);
    int unsigned n;
    logic        lvl;
    n   = $urandom_range(1, 4);
    lvl = first_lvl;
    repeat (n) begin
      sample_after(lvl, $urandom_range(0, 2));
      lvl = ~lvl;
    end
  endtask

  // stop offering polls and wait until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (ResultLatency + 2) @(posedge clk_i);
  endtask

  // write one register over the config port, then read it back
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare_field("register readback", value, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only while idle: every result back before the first write
  task automatic load_settings(logic [15:0] deb, logic [31:0] lp, logic [15:0] win,
                               logic [31:0] boot, logic al);
    drain_results();
    write_reg(REG_DEBOUNCE, {16'd0, deb});
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_MULTI_WIN, {16'd0, win});
    write_reg(REG_BOOT_HOLD, boot);
    write_reg(REG_ACTIVE_LOW, {31'd0, al});
    cur_active_low = al;
  endtask

  // mostly well-formed button activity, with commands and noise mixed in
  task automatic run_episodes(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned clicks;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 7) == 0) sender_calm = ~sender_calm;
      if ($urandom_range(0, 7) == 0) receiver_calm = ~receiver_calm;
      if ($urandom_range(0, 40) == 0) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // click run of one to four presses, sometimes with bounce on the edges
        clicks = $urandom_range(1, 4);
        repeat (clicks) begin
          if ($urandom_range(0, 2) == 0) bounce(1'b1);
          hold_level(1'b1, $urandom_range(1, 3), step_max);
          if ($urandom_range(0, 2) == 0) bounce(1'b0);
          hold_level(1'b0, $urandom_range(1, 3), step_max);
          sent += 4;
        end
      end else if (pick < 60) begin
        hold_level(1'b1, $urandom_range(3, 8), step_max * 3);
        sent += 5;
      end else if (pick < 70) begin
        // quiet time lets a click run close
        hold_level(1'b0, $urandom_range(1, 3), step_max * 4);
        sent += 2;
      end else if (pick < 78) begin
        put_poll(CMD_TAKE, 1'($urandom_range(0, 1)), clock_ms);
        sent++;
      end else if (pick < 83) begin
        put_poll(CMD_RESTART, 1'($urandom_range(0, 1)), clock_ms);
        sent++;
      end else if (pick < 88) begin
        put_poll(CMD_PRIME, 1'($urandom_range(0, 1)), clock_ms);
        sent++;
      end else if (pick < 93) begin
        bounce(1'($urandom_range(0, 1)));
        sent += 2;
      end else begin
        // raw noise: any command, any level, any time stamp
        put_poll(cmd_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
        sent++;
      end
    end
  endtask

  task automatic run_phase(phase_kind_e kind, int unsigned budget);
    case (kind)
      PH_RESET: begin
        load_settings(DebounceReset, LongPressReset, MultiWinReset, BootHoldReset,
                      1'($urandom_range(0, 1)));
        step_max = 32'd120;
      end
      PH_TIGHT: begin
        load_settings(16'($urandom_range(0, 30)), $urandom_range(40, 600),
                      16'($urandom_range(10, 300)), $urandom_range(50, 1500),
                      1'($urandom_range(0, 1)));
        step_max = $urandom_range(5, 120);
      end
      PH_ZERO: begin
        load_settings(16'd0, 32'd0, 16'd0, 32'd0, 1'($urandom_range(0, 1)));
        step_max = 32'd20;
      end
      default: begin
        load_settings(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                      1'($urandom_range(0, 1)));
        step_max = 32'd40000;
      end
    endcase
    put_poll(CMD_PRIME, 1'($urandom_range(0, 1)), clock_ms);
    if (kind == PH_MAX) begin
      // press accepted only after the full debounce, then a long press that needs
      // the whole 32 bit span between press and poll
      sample_after(1'b1, 32'd0);
      sample_after(1'b1, 32'd65535);
      sample_after(1'b1, 32'hFFFF_FFFF);
      sample_after(1'b0, 32'd0);
      sample_after(1'b0, 32'd65535);
    end
    run_episodes(budget);
  endtask

  // result side: random stalls per transfer, one long stall on request
  initial begin : result_sink
    int unsigned  stall_cycles;
    poll_result_t got;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall_cycles = LongHold;
        hold_request = 1'b0;
      end else begin
        stall_cycles = receiver_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = {pressed_o, event_res_o, finished_clicks_o, held_for_o, previous_hold_o};
      sb.check_result(got);
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("button_debounce_click_detector verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // not primed yet: everything reads zero, restart acts but leaves it unprimed
    put_poll(CMD_SAMPLE, 1'b0, 32'd1000);
    put_poll(CMD_TAKE, 1'b1, 32'hFFFF_FFFF);
    put_poll(CMD_RESTART, 1'b0, 32'd0);
    put_poll(CMD_PRIME, pin_for(1'b0), clock_ms);
    // press through debounce, take the event with a pin level that is ignored
    sample_after(1'b1, 32'd5);
    sample_after(1'b1, 32'd25);
    clock_ms += 32'd10;
    put_poll(CMD_TAKE, 1'($urandom_range(0, 1)), clock_ms);
    // two quick clicks then a quiet window: double click
    sample_after(1'b0, 32'd60);
    sample_after(1'b0, 32'd25);
    sample_after(1'b1, 32'd25);
    sample_after(1'b1, 32'd25);
    sample_after(1'b0, 32'd25);
    sample_after(1'b0, 32'd25);
    sample_after(1'b0, 32'd375);
    // long press, its release adds no click
    sample_after(1'b1, 32'd30);
    sample_after(1'b1, 32'd30);
    sample_after(1'b1, 32'd870);
    sample_after(1'b0, 32'd30);
    sample_after(1'b0, 32'd30);
    // primed while held: boot hold wins over long press on the same poll
    clock_ms += 32'd1000;
    put_poll(CMD_PRIME, pin_for(1'b1), clock_ms);
    sample_after(1'b1, 32'd2100);
    put_poll(CMD_TAKE, pin_for(1'b0), clock_ms);

    // click count saturation: instant debounce, window never closes until the end
    load_settings(16'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'($urandom_range(0, 1)));
    put_poll(CMD_PRIME, pin_for(1'b0), clock_ms);
    hold_request = 1'b1;
    for (int unsigned k = 0; k < ClickBurst; k++) begin
      if (k % 40 == 0) begin
        sender_calm   = 1'($urandom_range(0, 1));
        receiver_calm = 1'($urandom_range(0, 1));
      end
      sample_after(1'b1, $urandom_range(1, 20));
      sample_after(1'b0, $urandom_range(1, 20));
    end
    sample_after(1'b0, 32'd65535);
    put_poll(CMD_TAKE, 1'($urandom_range(0, 1)), clock_ms);

    // random phases over several register settings, one starting near the time wrap
    run_phase(PH_RESET, 8);
    hold_request = 1'b1;
    run_phase(PH_TIGHT, 8);
    run_phase(PH_ZERO, 8);
    clock_ms = 32'hFFFF_FF00;
    run_phase(PH_TIGHT, 8);
    run_phase(PH_MAX, 8);
    run_phase(PH_TIGHT, 8);
    run_phase(PH_TIGHT, 8);
    run_phase(PH_RESET, 8);

    drain_results();
    if (sb.errors == 0) begin
      $display("button_debounce_click_detector verification clean");
    end else begin
      $display("button_debounce_click_detector verification failed");
    end
    $finish;
  end

endmodule

FILE: button_debounce_click_detector.f
+incdir+sv
sv/bdc_pkg.sv
sv/button_debounce_click_detector.sv
verif/button_debounce_click_detector_tb.sv
